// ===== sv/asof_pkg.sv =====
// ----------------------------------------------------------------------------
// Azimuth sector overlap filter package
// Shared widths, command and register codes, turn constants and the CORDIC
// arctangent table.
// ----------------------------------------------------------------------------
package asof_pkg;

  localparam int CMD_W     = 2;
  localparam int SC_W      = 11;
  localparam int THR_W     = 17;
  localparam int CFG_W     = 17;
  localparam int CFG_IDX_W = 2;
  localparam int SECTOR_W  = 10;

  localparam logic [CMD_W-1:0] CMD_COUNT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TEST  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SECTOR_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHILD_THR    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PARENT_THR   = 2'd2;

  localparam int ACC_W        = 64;
  localparam int CORDIC_STEPS = 24;
  localparam int STEP_W       = 5;
  localparam int Z_W          = 27;
  localparam int TURN_W       = 25;
  localparam int FRAC_W       = 24;

  typedef logic [Z_W-1:0]    angle_t;
  typedef logic [TURN_W-1:0] turn_t;

  localparam angle_t QUARTER_TURN = 27'd16777216;
  localparam angle_t HALF_TURN    = 27'd33554432;
  localparam angle_t FULL_TURN    = 27'd67108864;

  // atan(2^-i) in units of 2^-26 turn.
  function automatic logic [23:0] atan_turn(input logic [STEP_W-1:0] step);
    logic [23:0] r;
    case (step)
      5'd0:    r = 24'd8388608;
      5'd1:    r = 24'd4952084;
      5'd2:    r = 24'd2616545;
      5'd3:    r = 24'd1328199;
      5'd4:    r = 24'd666677;
      5'd5:    r = 24'd333664;
      5'd6:    r = 24'd166872;
      5'd7:    r = 24'd83441;
      5'd8:    r = 24'd41721;
      5'd9:    r = 24'd20861;
      5'd10:   r = 24'd10430;
      5'd11:   r = 24'd5215;
      5'd12:   r = 24'd2608;
      5'd13:   r = 24'd1304;
      5'd14:   r = 24'd652;
      5'd15:   r = 24'd326;
      5'd16:   r = 24'd163;
      5'd17:   r = 24'd81;
      5'd18:   r = 24'd41;
      5'd19:   r = 24'd20;
      5'd20:   r = 24'd10;
      5'd21:   r = 24'd5;
      5'd22:   r = 24'd3;
      5'd23:   r = 24'd1;
      default: r = 24'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/asof_point_if.sv =====
// ----------------------------------------------------------------------------
// Point channel
// Valid/ready channel carrying one command beat with its point coordinates.
// ----------------------------------------------------------------------------
interface asof_point_if #(
  parameter int COORD_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic [asof_pkg::CMD_W-1:0]    cmd;
  logic                          cloud;
  logic signed [COORD_WIDTH-1:0] x_pos;
  logic signed [COORD_WIDTH-1:0] y_pos;

  modport source (output valid, cmd, cloud, x_pos, y_pos, input ready);
  modport sink   (input valid, cmd, cloud, x_pos, y_pos, output ready);
endinterface

// ===== sv/asof_result_if.sv =====
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying the overlap answer for one tested point.
// ----------------------------------------------------------------------------
interface asof_result_if;
  logic                          valid;
  logic                          ready;
  logic                          keep;
  logic                          cloud_echo;
  logic [asof_pkg::SECTOR_W-1:0] sector;

  modport source (output valid, keep, cloud_echo, sector, input ready);
  modport sink   (input valid, keep, cloud_echo, sector, output ready);
endinterface

// ===== sv/asof_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module asof_ram #(
  parameter int WIDTH = 34,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/asof_cordic.sv =====
// ----------------------------------------------------------------------------
// Iterative vectoring CORDIC
// Finds the first-quadrant angle of a magnitude pair in 2^-26 turn, one
// micro-rotation per cycle on a shared shift/add unit.
// ----------------------------------------------------------------------------
module asof_cordic #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [COORD_WIDTH-1:0] ux,
  input  logic [COORD_WIDTH-1:0] uy,
  output logic                   done,
  output asof_pkg::turn_t        angle
);

  localparam int SHIFT = asof_pkg::ACC_W - 3 - COORD_WIDTH;
  localparam logic signed [asof_pkg::Z_W-1:0] Z_QUARTER = asof_pkg::QUARTER_TURN;

  logic                                 run;
  logic [asof_pkg::STEP_W-1:0]          step;
  logic                                 zero;
  logic signed [asof_pkg::ACC_W-1:0]    xs;
  logic signed [asof_pkg::ACC_W-1:0]    ys;
  logic signed [asof_pkg::ACC_W-1:0]    dx;
  logic signed [asof_pkg::ACC_W-1:0]    dy;
  logic signed [asof_pkg::Z_W-1:0]      z;
  logic signed [asof_pkg::Z_W-1:0]      dz;

  assign dx = ys >>> step;
  assign dy = xs >>> step;
  assign dz = $signed(asof_pkg::Z_W'(asof_pkg::atan_turn(step)));

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
      end else if (run && step == asof_pkg::STEP_W'(asof_pkg::CORDIC_STEPS - 1)) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      step <= '0;
      zero <= (ux == '0) && (uy == '0);
      xs   <= $signed(asof_pkg::ACC_W'(ux) << SHIFT);
      ys   <= $signed(asof_pkg::ACC_W'(uy) << SHIFT);
      z    <= '0;
    end else if (run) begin
      step <= step + 1'b1;
      if (!ys[asof_pkg::ACC_W-1]) begin
        xs <= xs + dx;
        ys <= ys - dy;
        z  <= z + dz;
      end else begin
        xs <= xs - dx;
        ys <= ys + dy;
        z  <= z - dz;
      end
    end
  end

  always_comb begin
    if (zero || z < 0) begin
      angle = '0;
    end else if (z > Z_QUARTER) begin
      angle = asof_pkg::TURN_W'(asof_pkg::QUARTER_TURN);
    end else begin
      angle = asof_pkg::TURN_W'(z);
    end
  end

endmodule

// ===== sv/azimuth_sector_overlap_filter.sv =====
// ----------------------------------------------------------------------------
// Azimuth sector overlap filter
// Maps each point's azimuth to a sector and keeps saturating child and parent
// counts per sector; test points report whether both counts reach threshold.
// ----------------------------------------------------------------------------
//  Channel   Dir   Handshake       Beat contents
//  points    in    valid/ready     cmd, cloud, x_pos, y_pos
//  results   out   valid/ready     keep, cloud_echo, sector (test beats only)
//  cfg       in    cfg_we only     cfg_index, cfg_data
//
//  A count or test beat passes through the accept, 24 CORDIC iterations and
//  a done step, then the turn, multiply, index, RAM read and update steps.
//  A clear beat, and reset, start a pass that zeroes all MAX_SECTORS entries
//  of the counter RAM one entry per cycle; no point beat is taken meanwhile.
//  The result sits in an output register; a stalled result only holds a
//  following test beat at its final step.
// ----------------------------------------------------------------------------
module azimuth_sector_overlap_filter #(
  parameter int MAX_SECTORS = 1024,
  parameter int COUNT_WIDTH = 17,
  parameter int COORD_WIDTH = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [asof_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [asof_pkg::CFG_W-1:0]         cfg_data,
  asof_point_if.sink                         points,
  asof_result_if.source                      results
);

  localparam int AW     = $clog2(MAX_SECTORS);
  localparam int NW_RAW = $clog2(MAX_SECTORS + 1);
  localparam int NW     = (NW_RAW > asof_pkg::SC_W) ? NW_RAW : asof_pkg::SC_W;
  localparam int PW     = asof_pkg::TURN_W + NW;
  localparam int TW     = (COUNT_WIDTH > asof_pkg::THR_W) ? COUNT_WIDTH : asof_pkg::THR_W;
  localparam int RW     = 2 * COUNT_WIDTH;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_CORDIC = 3'd2;
  localparam logic [2:0] S_TURN   = 3'd3;
  localparam logic [2:0] S_MUL    = 3'd4;
  localparam logic [2:0] S_INDEX  = 3'd5;
  localparam logic [2:0] S_READ   = 3'd6;
  localparam logic [2:0] S_UPDATE = 3'd7;

  logic [2:0]                     state;
  logic [AW-1:0]                  clr_addr;
  logic [asof_pkg::SC_W-1:0]      sector_count;
  logic [asof_pkg::THR_W-1:0]     child_thr;
  logic [asof_pkg::THR_W-1:0]     parent_thr;
  logic [asof_pkg::CMD_W-1:0]     cmd_q;
  logic                           cloud_q;
  logic                           xn_q;
  logic                           yn_q;
  asof_pkg::turn_t                turn_q;
  logic [PW-1:0]                  prod_q;
  logic [AW-1:0]                  sec_q;
  logic                           out_valid;
  logic                           keep_q;
  logic                           cloud_echo_q;
  logic [asof_pkg::SECTOR_W-1:0]  sector_q;

  logic                           accept;
  logic                           start;
  logic                           x_neg;
  logic                           y_neg;
  logic [COORD_WIDTH-1:0]         x_raw;
  logic [COORD_WIDTH-1:0]         y_raw;
  logic [COORD_WIDTH-1:0]         x_mag;
  logic [COORD_WIDTH-1:0]         y_mag;
  logic                           cordic_done;
  asof_pkg::turn_t                angle;
  asof_pkg::angle_t               turn_full;
  logic [NW-1:0]                  sc_ext;
  logic [NW-1:0]                  n_eff;
  logic [NW-1:0]                  idx_raw;
  logic [NW-1:0]                  idx_lim;
  logic                           ram_we;
  logic [AW-1:0]                  ram_waddr;
  logic [RW-1:0]                  ram_wdata;
  logic [RW-1:0]                  ram_rdata;
  logic [COUNT_WIDTH-1:0]         child_cnt;
  logic [COUNT_WIDTH-1:0]         parent_cnt;
  logic [COUNT_WIDTH-1:0]         sel_cnt;
  logic [COUNT_WIDTH-1:0]         inc_cnt;
  logic                           slot_free;
  logic                           keep_now;

  assign points.ready = (state == S_IDLE);
  assign accept       = points.valid && points.ready;
  assign start        = accept && (points.cmd == asof_pkg::CMD_COUNT ||
                                   points.cmd == asof_pkg::CMD_TEST);

  assign x_raw = $unsigned(points.x_pos);
  assign y_raw = $unsigned(points.y_pos);
  assign x_neg = x_raw[COORD_WIDTH-1];
  assign y_neg = y_raw[COORD_WIDTH-1];
  assign x_mag = x_neg ? (~x_raw + 1'b1) : x_raw;
  assign y_mag = y_neg ? (~y_raw + 1'b1) : y_raw;

  asof_cordic #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_cordic (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .ux   (x_mag),
    .uy   (y_mag),
    .done (cordic_done),
    .angle(angle)
  );

  always_comb begin
    case ({xn_q, yn_q})
      2'b00:   turn_full = asof_pkg::HALF_TURN + asof_pkg::Z_W'(angle);
      2'b10:   turn_full = asof_pkg::FULL_TURN - asof_pkg::Z_W'(angle);
      2'b11:   turn_full = asof_pkg::Z_W'(angle);
      default: turn_full = asof_pkg::HALF_TURN - asof_pkg::Z_W'(angle);
    endcase
  end

  assign sc_ext = NW'(sector_count);

  always_comb begin
    if (sc_ext == '0) begin
      n_eff = NW'(1);
    end else if (sc_ext > NW'(MAX_SECTORS)) begin
      n_eff = NW'(MAX_SECTORS);
    end else begin
      n_eff = sc_ext;
    end
  end

  assign idx_raw = prod_q[asof_pkg::FRAC_W +: NW];
  assign idx_lim = (idx_raw > n_eff - 1'b1) ? (n_eff - 1'b1) : idx_raw;

  assign child_cnt  = ram_rdata[COUNT_WIDTH-1:0];
  assign parent_cnt = ram_rdata[RW-1:COUNT_WIDTH];
  assign sel_cnt    = cloud_q ? parent_cnt : child_cnt;
  assign inc_cnt    = (sel_cnt == '1) ? sel_cnt : sel_cnt + 1'b1;
  assign keep_now   = (TW'(child_cnt) >= TW'(child_thr)) &&
                      (TW'(parent_cnt) >= TW'(parent_thr));
  assign slot_free  = !out_valid || results.ready;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = sec_q;
    ram_wdata = cloud_q ? {inc_cnt, child_cnt} : {parent_cnt, inc_cnt};
    if (state == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else if (state == S_UPDATE && cmd_q == asof_pkg::CMD_COUNT) begin
      ram_we = 1'b1;
    end
  end

  asof_ram #(
    .WIDTH(RW),
    .DEPTH(MAX_SECTORS)
  ) u_counts (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(sec_q),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sector_count <= asof_pkg::SC_W'(360);
      child_thr    <= asof_pkg::THR_W'(1);
      parent_thr   <= asof_pkg::THR_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        asof_pkg::CFG_SECTOR_COUNT: sector_count <= cfg_data[asof_pkg::SC_W-1:0];
        asof_pkg::CFG_CHILD_THR:    child_thr    <= cfg_data[asof_pkg::THR_W-1:0];
        asof_pkg::CFG_PARENT_THR:   parent_thr   <= cfg_data[asof_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_UPDATE && cmd_q == asof_pkg::CMD_TEST && slot_free) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(MAX_SECTORS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            case (points.cmd)
              asof_pkg::CMD_CLEAR: begin
                state    <= S_CLEAR;
                clr_addr <= '0;
              end
              asof_pkg::CMD_COUNT, asof_pkg::CMD_TEST: state <= S_CORDIC;
              default: ;
            endcase
          end
        end
        S_CORDIC: begin
          if (cordic_done) begin
            state <= S_TURN;
          end
        end
        S_TURN:  state <= S_MUL;
        S_MUL:   state <= S_INDEX;
        S_INDEX: state <= S_READ;
        S_READ:  state <= S_UPDATE;
        S_UPDATE: begin
          if (cmd_q == asof_pkg::CMD_COUNT || slot_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q   <= points.cmd;
      cloud_q <= points.cloud;
      xn_q    <= x_neg;
      yn_q    <= y_neg;
    end
    if (state == S_TURN) begin
      turn_q <= turn_full[asof_pkg::Z_W-1:2];
    end
    if (state == S_MUL) begin
      prod_q <= PW'(turn_q) * PW'(n_eff);
    end
    if (state == S_INDEX) begin
      sec_q <= AW'(idx_lim);
    end
    if (state == S_UPDATE && cmd_q == asof_pkg::CMD_TEST && slot_free) begin
      keep_q       <= keep_now;
      cloud_echo_q <= cloud_q;
      sector_q     <= asof_pkg::SECTOR_W'(sec_q);
    end
  end

  assign results.valid      = out_valid;
  assign results.keep       = keep_q;
  assign results.cloud_echo = cloud_echo_q;
  assign results.sector     = sector_q;

endmodule
